### rtl/apwlt_pkg.sv
// ----------------------------------------------------------------------------
// apwlt_pkg
// Breakpoint tables and shared types for the piecewise-linear temperature
// linearizer.
// ----------------------------------------------------------------------------
package apwlt_pkg;

    localparam int NUM_POINTS  = 11;
    localparam int NUM_SEGS    = NUM_POINTS - 1;
    localparam int COUNT_W     = 12;
    localparam int TEMP_W      = 11;
    localparam int SEG_W       = $clog2(NUM_POINTS);
    // Slope = ceil(dy * 2^SLOPE_SHIFT / dx). With dx*(dx-1) < 2^SLOPE_SHIFT
    // for every segment, (off * slope) >> SLOPE_SHIFT equals floor(off*dy/dx).
    localparam int SLOPE_SHIFT = 20;
    localparam int SLOPE_W     = 20;
    localparam int PROD_W      = COUNT_W + SLOPE_W;
    localparam int QUOT_W      = PROD_W - SLOPE_SHIFT;

    localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

    // Breakpoint counts (converter codes).
    localparam logic [COUNT_W-1:0] BP_COUNT [NUM_POINTS] = '{
        12'd0,    12'd300,  12'd482,  12'd857,  12'd1068, 12'd1763,
        12'd2074, 12'd2472, 12'd3021, 12'd3581, 12'd4095
    };

    // Breakpoint temperatures in 0.05 degree steps.
    localparam logic [TEMP_W-1:0] BP_TEMP [NUM_POINTS] = '{
        11'd0,    11'd76,   11'd128,  11'd358,  11'd464,  11'd858,
        11'd1006, 11'd1224, 11'd1502, 11'd1776, 11'd2000
    };

    // Scaled reciprocal slope of each segment.
    localparam logic [SLOPE_W-1:0] SEG_SLOPE [NUM_SEGS] = '{
        20'd265640, 20'd299594, 20'd643127, 20'd526773, 20'd594445,
        20'd499001, 20'd574346, 20'd530973, 20'd513054, 20'd456967
    };

    // Work carried from the segment stage to the multiply stage.
    typedef struct packed {
        logic                top;    // count at or above last breakpoint
        logic [COUNT_W-1:0]  off;    // count minus segment start
        logic [SLOPE_W-1:0]  slope;  // scaled segment slope
        logic [TEMP_W-1:0]   base;   // temperature at segment start
    } seg_work_t;

endpackage

### rtl/adc_piecewise_linear_temperature_core.sv
// ----------------------------------------------------------------------------
// adc_piecewise_linear_temperature_core
// Linearizes a 12-bit converter count into temperature (0.05 degree steps)
// through an 11-point breakpoint table with linear interpolation.
// ----------------------------------------------------------------------------
// Each accepted item carries one converter count and yields exactly one
// temperature item, floor of the interpolated value in 0.05 degree steps
// (0..2000, 2000 = 100.0 degrees; counts at the last breakpoint give 2000).
// The block takes one item per clock while the output is not stalled and holds
// no state between items. Each item passes through the input register,
// segment register (parallel breakpoint compares pick the segment, its start
// count is subtracted), result register (one 12x20 multiply by the segment's
// scaled reciprocal slope, shift, add of the base temperature). Each stage
// moves forward whenever the stage after it is empty or emptying, so the
// input side keeps taking items while a result waits on m_tready until all
// three stages are full.
// ----------------------------------------------------------------------------
module adc_piecewise_linear_temperature_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_count, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [10:0] temp_twentieths, [15:11] zero
);

    // ---------------- stage enables ----------------
    logic a_vld_reg, a_vld_next;
    logic b_vld_reg, b_vld_next;
    logic m_vld_reg, m_vld_next;
    logic a_en, b_en, m_en;

    assign m_en     = !m_vld_reg || m_tready;
    assign b_en     = !b_vld_reg || m_en;
    assign a_en     = !a_vld_reg || b_en;
    assign s_tready = a_en;
    assign m_tvalid = m_vld_reg;

    assign a_vld_next = a_en ? s_tvalid  : a_vld_reg;
    assign b_vld_next = b_en ? a_vld_reg : b_vld_reg;
    assign m_vld_next = m_en ? b_vld_reg : m_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
            m_vld_reg <= m_vld_next;
        end
    end

    // ---------------- input register ----------------
    logic [apwlt_pkg::COUNT_W-1:0] a_count_reg, a_count_next;

    assign a_count_next = a_en ? s_tdata[apwlt_pkg::COUNT_W-1:0] : a_count_reg;

    always_ff @(posedge aclk) begin
        a_count_reg <= a_count_next;
    end

    // ---------------- segment stage ----------------
    // Breakpoints are ascending, so the segment is the last one whose start
    // is not above the count.
    logic [apwlt_pkg::SEG_W-1:0] seg_idx;
    apwlt_pkg::seg_work_t        seg_work;
    apwlt_pkg::seg_work_t        b_work_reg, b_work_next;

    always_comb begin
        seg_idx = '0;
        for (int i = 1; i < apwlt_pkg::NUM_SEGS; i++) begin
            if (a_count_reg >= apwlt_pkg::BP_COUNT[i]) begin
                seg_idx = apwlt_pkg::SEG_W'(i);
            end
        end
    end

    always_comb begin
        seg_work.top   = (a_count_reg >= apwlt_pkg::BP_COUNT[apwlt_pkg::NUM_POINTS-1]);
        seg_work.off   = a_count_reg - apwlt_pkg::BP_COUNT[seg_idx];
        seg_work.slope = apwlt_pkg::SEG_SLOPE[seg_idx];
        seg_work.base  = apwlt_pkg::BP_TEMP[seg_idx];
    end

    assign b_work_next = b_en ? seg_work : b_work_reg;

    always_ff @(posedge aclk) begin
        b_work_reg <= b_work_next;
    end

    // ---------------- multiply stage ----------------
    logic [apwlt_pkg::PROD_W-1:0] prod;
    logic [apwlt_pkg::QUOT_W-1:0] quot;
    logic [apwlt_pkg::TEMP_W:0]   sum;
    logic [apwlt_pkg::TEMP_W-1:0] temp_val;
    logic [apwlt_pkg::TEMP_W-1:0] m_temp_reg, m_temp_next;

    assign prod = apwlt_pkg::PROD_W'(b_work_reg.off) * apwlt_pkg::PROD_W'(b_work_reg.slope);
    assign quot = prod[apwlt_pkg::PROD_W-1:apwlt_pkg::SLOPE_SHIFT];
    assign sum  = {1'b0, b_work_reg.base}
                + (apwlt_pkg::TEMP_W+1)'(quot);

    always_comb begin
        priority if (b_work_reg.top) begin
            temp_val = apwlt_pkg::BP_TEMP[apwlt_pkg::NUM_POINTS-1];
        end else if (sum[apwlt_pkg::TEMP_W]) begin
            temp_val = apwlt_pkg::TEMP_MAX;   // saturate to field range
        end else begin
            temp_val = sum[apwlt_pkg::TEMP_W-1:0];
        end
    end

    assign m_temp_next = m_en ? temp_val : m_temp_reg;

    always_ff @(posedge aclk) begin
        m_temp_reg <= m_temp_next;
    end

    assign m_tdata = {(16 - apwlt_pkg::TEMP_W)'(0), m_temp_reg};

    // ---------------- assertions ----------------
`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> a_vld_reg)
        else $error("accepted item did not reach input register");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (a_vld_reg && b_vld_reg && m_vld_reg && !m_tready))
        else $error("input stalled with a free stage");

    a_top_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_vld_reg && b_en && a_count_reg == apwlt_pkg::BP_COUNT[apwlt_pkg::NUM_POINTS-1])
        |=> b_work_reg.top)
        else $error("top breakpoint not flagged");

    a_off_in_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_vld_reg && !b_work_reg.top) |-> (b_work_reg.off < 12'd695))
        else $error("segment offset beyond widest segment");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg |-> (m_temp_reg <= apwlt_pkg::BP_TEMP[apwlt_pkg::NUM_POINTS-1]))
        else $error("temperature above table maximum");
`endif

endmodule
